>>> hdl/bog_pkg.sv
// Shared types, constants and helpers for the broadcast offset generator.
package bog_pkg;

   localparam int AXES       = 4;
   localparam int AXIS_IDX_W = 2;
   localparam int NUM_REGS   = 2 * AXES;
   localparam int REG_IDX_W  = 3;
   localparam int DIM_W      = 13;
   localparam int CNT_W      = 12;
   localparam int OFS_W      = 24;
   localparam int STR_W      = OFS_W + 1;
   localparam int PROD_W     = DIM_W + STR_W;
   localparam int DIM_LIMIT  = 4096;

   // axis order, outermost first
   localparam logic [AXIS_IDX_W-1:0] AXIS_BATCH   = 2'd0;
   localparam logic [AXIS_IDX_W-1:0] AXIS_CHANNEL = 2'd1;
   localparam logic [AXIS_IDX_W-1:0] AXIS_HEIGHT  = 2'd2;
   localparam logic [AXIS_IDX_W-1:0] AXIS_WIDTH   = 2'd3;

   // setup sequencer phases
   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_S1  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_S0  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LEN = 3'd2;
   localparam logic [PHASE_W-1:0] PH_R0  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_R1  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_R2  = 3'd5;
   localparam logic [PHASE_W-1:0] PH_R3  = 3'd6;

   // largest legal element count; anything above saturates to one more
   localparam logic [STR_W-1:0] MAX_LEN = STR_W'(1) << OFS_W;
   localparam logic [STR_W-1:0] LEN_SAT = MAX_LEN + STR_W'(1);

   typedef logic [AXES-1:0][CNT_W-1:0] cnt_vec_type;
   typedef logic [AXES-1:0][OFS_W-1:0] ofs_vec_type;
   typedef logic [AXES-1:0][DIM_W-1:0] dim_vec_type;

   typedef struct packed {
      logic                  ok;
      logic                  busy;
      dim_vec_type           own_dim;
      ofs_vec_type           own_step;
      ofs_vec_type           oth_step;
      logic                  load_en;
      logic [AXIS_IDX_W-1:0] load_idx;
      logic [OFS_W-1:0]      load_own;
      logic [OFS_W-1:0]      load_oth;
   } shape_type;

   typedef struct packed {
      logic [OFS_W-1:0] own_offset;
      logic [OFS_W-1:0] other_offset;
      logic             last;
      logic             error;
   } result_type;

   function automatic logic [STR_W-1:0] sat_stride(input logic [PROD_W-1:0] p);
      logic [STR_W-1:0] r;
      if (p > PROD_W'(MAX_LEN)) begin
         r = LEN_SAT;
      end else begin
         r = p[STR_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> hdl/bog_setup.sv
// Shape registers, stride setup sequencer and offset rebuild after a shape write.
module bog_setup (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [bog_pkg::REG_IDX_W-1:0]   csr_index,
   input  logic [bog_pkg::DIM_W-1:0]       csr_write_data,
   input  bog_pkg::cnt_vec_type            counters,
   output bog_pkg::shape_type              shape
);

   logic [bog_pkg::NUM_REGS-1:0][bog_pkg::DIM_W-1:0] dim_ff;
   logic                           busy_ff, busy_in;
   logic [bog_pkg::PHASE_W-1:0]    phase_ff, phase_in;
   logic [bog_pkg::STR_W-1:0]      s1_ff, s0_ff, t1_ff, t0_ff;
   logic                           ok_ff;
   logic [bog_pkg::OFS_W-1:0]      acc_own_ff, acc_own_in;
   logic [bog_pkg::OFS_W-1:0]      acc_oth_ff, acc_oth_in;
   logic [bog_pkg::DIM_W-1:0]      mo_a, mt_a;
   logic [bog_pkg::STR_W-1:0]      mo_b, mt_b;
   logic [bog_pkg::PROD_W-1:0]     prod_o, prod_t;
   logic [bog_pkg::AXIS_IDX_W-1:0] rk;
   logic [bog_pkg::AXES-1:0]       oth_unit;
   logic                           legal;
   logic                           rebuild;
   logic [bog_pkg::OFS_W-1:0]      base_own, base_oth;

   // legality of each axis pair
   always_comb begin
      legal = 1'b1;
      for (int k = 0; k < bog_pkg::AXES; k++) begin
         oth_unit[k] = (dim_ff[bog_pkg::AXES+k] == bog_pkg::DIM_W'(1));
         if (dim_ff[k] == '0 || dim_ff[bog_pkg::AXES+k] == '0 ||
             dim_ff[k] > bog_pkg::DIM_W'(bog_pkg::DIM_LIMIT) ||
             dim_ff[bog_pkg::AXES+k] > bog_pkg::DIM_W'(bog_pkg::DIM_LIMIT) ||
             (dim_ff[bog_pkg::AXES+k] != dim_ff[k] && !oth_unit[k])) begin
            legal = 1'b0;
         end
      end
   end

   assign rk      = bog_pkg::AXIS_IDX_W'(phase_ff - bog_pkg::PH_R0);
   assign rebuild = busy_ff && (phase_ff inside {[bog_pkg::PH_R0:bog_pkg::PH_R3]});

   // one shared multiplier per tensor, operands picked by phase
   always_comb begin
      mo_a = '0;
      mo_b = '0;
      mt_a = '0;
      mt_b = '0;
      case (phase_ff)
         bog_pkg::PH_S1: begin
            mo_a = dim_ff[bog_pkg::AXIS_HEIGHT];
            mo_b = bog_pkg::STR_W'(dim_ff[bog_pkg::AXIS_WIDTH]);
            mt_a = dim_ff[bog_pkg::AXES + 2];
            mt_b = bog_pkg::STR_W'(dim_ff[bog_pkg::AXES + 3]);
         end
         bog_pkg::PH_S0: begin
            mo_a = dim_ff[bog_pkg::AXIS_CHANNEL];
            mo_b = s1_ff;
            mt_a = dim_ff[bog_pkg::AXES + 1];
            mt_b = t1_ff;
         end
         bog_pkg::PH_LEN: begin
            mo_a = dim_ff[bog_pkg::AXIS_BATCH];
            mo_b = s0_ff;
         end
         bog_pkg::PH_R0: begin
            mo_a = bog_pkg::DIM_W'(counters[bog_pkg::AXIS_BATCH]);
            mo_b = s0_ff;
            mt_a = mo_a;
            mt_b = t0_ff;
         end
         bog_pkg::PH_R1: begin
            mo_a = bog_pkg::DIM_W'(counters[bog_pkg::AXIS_CHANNEL]);
            mo_b = s1_ff;
            mt_a = mo_a;
            mt_b = t1_ff;
         end
         bog_pkg::PH_R2: begin
            mo_a = bog_pkg::DIM_W'(counters[bog_pkg::AXIS_HEIGHT]);
            mo_b = bog_pkg::STR_W'(dim_ff[bog_pkg::AXIS_WIDTH]);
            mt_a = mo_a;
            mt_b = bog_pkg::STR_W'(dim_ff[bog_pkg::AXES + 3]);
         end
         bog_pkg::PH_R3: begin
            mo_a = bog_pkg::DIM_W'(counters[bog_pkg::AXIS_WIDTH]);
            mo_b = bog_pkg::STR_W'(1);
            mt_a = mo_a;
            mt_b = mo_b;
         end
         default: begin
            mo_a = '0;
         end
      endcase
   end

   assign prod_o = bog_pkg::PROD_W'(mo_a) * bog_pkg::PROD_W'(mo_b);
   assign prod_t = bog_pkg::PROD_W'(mt_a) * bog_pkg::PROD_W'(mt_b);

   // running prefix offsets, outermost axis first
   always_comb begin
      base_own   = (phase_ff == bog_pkg::PH_R0) ? '0 : acc_own_ff;
      base_oth   = (phase_ff == bog_pkg::PH_R0) ? '0 : acc_oth_ff;
      acc_own_in = base_own + prod_o[bog_pkg::OFS_W-1:0];
      acc_oth_in = base_oth + (oth_unit[rk] ? '0 : prod_t[bog_pkg::OFS_W-1:0]);
   end

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      if (csr_write_en) begin
         busy_in  = 1'b1;
         phase_in = bog_pkg::PH_S1;
      end else if (busy_ff) begin
         phase_in = phase_ff + bog_pkg::PHASE_W'(1);
         if (phase_ff == bog_pkg::PH_R3) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= bog_pkg::PH_S1;
         ok_ff    <= 1'b1;
         s1_ff    <= bog_pkg::STR_W'(1);
         s0_ff    <= bog_pkg::STR_W'(1);
         t1_ff    <= bog_pkg::STR_W'(1);
         t0_ff    <= bog_pkg::STR_W'(1);
         for (int k = 0; k < bog_pkg::NUM_REGS; k++) begin
            dim_ff[k] <= bog_pkg::DIM_W'(1);
         end
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         if (csr_write_en) begin
            dim_ff[csr_index] <= csr_write_data;
         end
         if (busy_ff && phase_ff == bog_pkg::PH_S1) begin
            s1_ff <= bog_pkg::sat_stride(prod_o);
            t1_ff <= bog_pkg::sat_stride(prod_t);
         end
         if (busy_ff && phase_ff == bog_pkg::PH_S0) begin
            s0_ff <= bog_pkg::sat_stride(prod_o);
            t0_ff <= bog_pkg::sat_stride(prod_t);
         end
         if (busy_ff && phase_ff == bog_pkg::PH_LEN) begin
            ok_ff <= legal && (prod_o <= bog_pkg::PROD_W'(bog_pkg::MAX_LEN));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rebuild) begin
         acc_own_ff <= acc_own_in;
         acc_oth_ff <= acc_oth_in;
      end
   end

   always_comb begin
      shape.ok       = ok_ff;
      shape.busy     = busy_ff;
      for (int k = 0; k < bog_pkg::AXES; k++) begin
         shape.own_dim[k] = dim_ff[k];
      end
      shape.own_step[bog_pkg::AXIS_BATCH]   = s0_ff[bog_pkg::OFS_W-1:0];
      shape.own_step[bog_pkg::AXIS_CHANNEL] = s1_ff[bog_pkg::OFS_W-1:0];
      shape.own_step[bog_pkg::AXIS_HEIGHT]  =
         bog_pkg::OFS_W'(dim_ff[bog_pkg::AXIS_WIDTH]);
      shape.own_step[bog_pkg::AXIS_WIDTH]   = bog_pkg::OFS_W'(1);
      shape.oth_step[bog_pkg::AXIS_BATCH]   =
         oth_unit[0] ? '0 : t0_ff[bog_pkg::OFS_W-1:0];
      shape.oth_step[bog_pkg::AXIS_CHANNEL] =
         oth_unit[1] ? '0 : t1_ff[bog_pkg::OFS_W-1:0];
      shape.oth_step[bog_pkg::AXIS_HEIGHT]  =
         oth_unit[2] ? '0 : bog_pkg::OFS_W'(dim_ff[bog_pkg::AXES + 3]);
      shape.oth_step[bog_pkg::AXIS_WIDTH]   =
         oth_unit[3] ? '0 : bog_pkg::OFS_W'(1);
      shape.load_en  = rebuild;
      shape.load_idx = rk;
      shape.load_own = acc_own_in;
      shape.load_oth = acc_oth_in;
   end

`ifndef SYNTHESIS
   a_busy_ends_after_rebuild: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) && !$past(reset) |-> $past(phase_ff) == bog_pkg::PH_R3)
      else $error("setup sequencer left busy early");
`endif

endmodule

>>> hdl/bog_walker.sv
// Axis counters and per-level prefix offsets; forms one offset pair per request.
module bog_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic                  restart,
   input  bog_pkg::shape_type    shape,
   output bog_pkg::cnt_vec_type  counters,
   output bog_pkg::result_type   result
);

   bog_pkg::cnt_vec_type cnt_ff, cnt_in, c_eff;
   bog_pkg::ofs_vec_type own_q_ff, own_q_in, own_e;
   bog_pkg::ofs_vec_type oth_q_ff, oth_q_in, oth_e;
   logic [bog_pkg::AXES-1:0]       wrap;
   logic [bog_pkg::AXIS_IDX_W-1:0] sel;
   logic                           found;
   logic [bog_pkg::OFS_W-1:0]      own_nxt, oth_nxt;

   assign c_eff = restart ? '0 : cnt_ff;
   assign own_e = restart ? '0 : own_q_ff;
   assign oth_e = restart ? '0 : oth_q_ff;

   // innermost axis that can still count up
   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int k = 0; k < bog_pkg::AXES; k++) begin
         wrap[k] = (bog_pkg::DIM_W'(c_eff[k]) + bog_pkg::DIM_W'(1)) >= shape.own_dim[k];
         if (!wrap[k]) begin
            sel   = bog_pkg::AXIS_IDX_W'(k);
            found = 1'b1;
         end
      end
   end

   // q[k] is the offset with every axis inside k at zero, so bumping axis k
   // is one add and every inner level takes the same value
   assign own_nxt = own_e[sel] + shape.own_step[sel];
   assign oth_nxt = oth_e[sel] + shape.oth_step[sel];

   always_comb begin
      for (int j = 0; j < bog_pkg::AXES; j++) begin
         if (!found) begin
            cnt_in[j]   = '0;
            own_q_in[j] = '0;
            oth_q_in[j] = '0;
         end else if (bog_pkg::AXIS_IDX_W'(j) > sel) begin
            cnt_in[j]   = '0;
            own_q_in[j] = own_nxt;
            oth_q_in[j] = oth_nxt;
         end else if (bog_pkg::AXIS_IDX_W'(j) == sel) begin
            cnt_in[j]   = c_eff[j] + bog_pkg::CNT_W'(1);
            own_q_in[j] = own_nxt;
            oth_q_in[j] = oth_nxt;
         end else begin
            cnt_in[j]   = c_eff[j];
            own_q_in[j] = own_e[j];
            oth_q_in[j] = oth_e[j];
         end
      end
   end

   always_comb begin
      result.error        = !shape.ok;
      result.own_offset   = shape.ok ? own_e[bog_pkg::AXIS_WIDTH] : '0;
      result.other_offset = shape.ok ? oth_e[bog_pkg::AXIS_WIDTH] : '0;
      result.last         = shape.ok && (&wrap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         own_q_ff <= '0;
         oth_q_ff <= '0;
      end else if (shape.load_en) begin
         own_q_ff[shape.load_idx] <= shape.load_own;
         oth_q_ff[shape.load_idx] <= shape.load_oth;
      end else if (step_en) begin
         if (shape.ok) begin
            cnt_ff   <= cnt_in;
            own_q_ff <= own_q_in;
            oth_q_ff <= oth_q_in;
         end else begin
            // no advance on a bad shape, but a restart still lands
            cnt_ff   <= c_eff;
            own_q_ff <= own_e;
            oth_q_ff <= oth_e;
         end
      end
   end

   assign counters = cnt_ff;

`ifndef SYNTHESIS
   a_last_wraps_to_zero: assert property (@(posedge clock) disable iff (reset)
      step_en && shape.ok && result.last |=> cnt_ff == '0 && own_q_ff == '0)
      else $error("walk did not return to element zero after last pair");

   a_restart_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      step_en && restart && shape.ok |->
         result.own_offset == '0 && result.other_offset == '0)
      else $error("restart did not emit element zero");
`endif

endmodule

>>> hdl/broadcast_offset_generator.sv
// Top level: broadcast offset generator with request and response handshakes.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  req_restart
//   rsp      out        rsp_valid/rsp_stall  rsp_own_offset, rsp_other_offset,
//                                            rsp_last, rsp_error
//   csr      in         csr_write_en         csr_index, csr_write_data
//
// One request per cycle while req_stall is low; its response sits in the output register in the next cycle.
// Offsets come from per-axis prefix registers updated with one add per request.
// A shape write starts a stride and offset rebuild (phases S1, S0, LEN, R0 to R3); requests stall meanwhile.
// Reset sets all shapes to 1, counters and offsets to zero, and needs no sweep.
// A stalled response holds and stalls requests only while it is not taken.
module broadcast_offset_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bog_pkg::OFS_W-1:0]     rsp_own_offset,
   output logic [bog_pkg::OFS_W-1:0]     rsp_other_offset,
   output logic                          rsp_last,
   output logic                          rsp_error,
   input  logic                          csr_write_en,
   input  logic [bog_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [bog_pkg::DIM_W-1:0]     csr_write_data
);

   bog_pkg::shape_type   shape;
   bog_pkg::cnt_vec_type counters;
   bog_pkg::result_type  step_result;
   bog_pkg::result_type  rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;

   bog_setup u_setup (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .counters       (counters),
      .shape          (shape)
   );

   bog_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .step_en  (accept),
      .restart  (req_restart),
      .shape    (shape),
      .counters (counters),
      .result   (step_result)
   );

   assign req_stall = shape.busy || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_own_offset   = rsp_ff.own_offset;
   assign rsp_other_offset = rsp_ff.other_offset;
   assign rsp_last         = rsp_ff.last;
   assign rsp_error        = rsp_ff.error;

`ifndef SYNTHESIS
   a_write_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> req_stall)
      else $error("request taken during shape rebuild");

   a_error_payload_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |->
         rsp_own_offset == '0 && rsp_other_offset == '0 && !rsp_last)
      else $error("error response carries offsets");
`endif

endmodule
